@@ rtl/fds_pkg.sv @@
// Package for the FAT16 directory name search block.
// Holds the on-disk constants, configuration register indexes and shared types.
// No dependencies.
package fds_pkg;

	localparam logic [7:0] SKIP_ATTR_MASK = 8'h1A;
	localparam logic [7:0] SPACE_CHAR     = 8'h20;
	localparam logic [7:0] DOT_CHAR       = 8'h2E;
	localparam logic [7:0] NUL_CHAR       = 8'h00;

	localparam int SECTOR_BYTES = 512;
	localparam int ENTRY_BYTES  = 32;
	localparam int POS_W        = $clog2(SECTOR_BYTES);
	localparam int OFF_W        = $clog2(ENTRY_BYTES);
	localparam int ENT_W        = POS_W - OFF_W;

	// Entry offsets that matter to the scan.
	localparam logic [OFF_W-1:0] OFF_ATTR      = OFF_W'(11);
	localparam logic [OFF_W-1:0] OFF_CLUSTER_L = OFF_W'(26);
	localparam logic [OFF_W-1:0] OFF_CLUSTER_H = OFF_W'(27);
	localparam logic [OFF_W-1:0] OFF_LENGTH    = OFF_W'(28);
	localparam logic [POS_W-1:0] POS_LAST      = POS_W'(SECTOR_BYTES - 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NAME_HEAD   = 2'd0,
		CFG_NAME_TAIL   = 2'd1,
		CFG_DATA_START  = 2'd2,
		CFG_CLUSTER_SZ  = 2'd3
	} cfg_reg_t;

	// Bytes 0..10 of a directory entry: 8 base characters, 3 extension characters.
	typedef logic [10:0][7:0] entry_name_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  entry_index;
		logic [15:0] start_cluster;
		logic [31:0] file_length;
	} scan_result_t;

	localparam int OUT_BITS  = 1 + 4 + 16 + 32 + 32;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

endpackage

@@ rtl/fds_name_match.sv @@
// Name comparison for one directory entry: builds "BASE.EXT" from the entry
// bytes and compares it as a NUL-terminated string with the search name.
// Depends on fds_pkg.
module fds_name_match
	import fds_pkg::*;
(
	input  entry_name_t  entry_name,
	input  logic [63:0]  name_head,
	input  logic [31:0]  name_tail,
	output logic         hit
);

	logic [12:0][7:0] search;
	logic [3:0]       cut;
	logic [12:0][7:0] built;

	assign search = {NUL_CHAR, name_tail, name_head};

	// Base name ends at its first space, or after all eight characters.
	always_comb begin
		cut = 4'd8;
		for (int k = 7; k >= 0; k--) begin
			if (entry_name[k] == SPACE_CHAR) begin
				cut = 4'(k);
			end
		end
	end

	always_comb begin
		logic [3:0] kk;
		logic [3:0] j;
		for (int k = 0; k < 13; k++) begin
			kk = 4'(k);
			j  = kk - cut;
			if (kk < cut) begin
				built[k] = entry_name[k % 8];
			end else if (kk == cut) begin
				built[k] = DOT_CHAR;
			end else if (j == 4'd1) begin
				built[k] = entry_name[8];
			end else if (j == 4'd2) begin
				built[k] = entry_name[9];
			end else if (j == 4'd3) begin
				built[k] = entry_name[10];
			end else begin
				built[k] = NUL_CHAR;
			end
		end
	end

	// Compare up to and including the first NUL of the built name.
	always_comb begin
		logic alive;
		logic ok;
		alive = 1'b1;
		ok    = 1'b1;
		for (int k = 0; k < 13; k++) begin
			if (alive) begin
				if (built[k] != search[k]) begin
					ok = 1'b0;
				end
				if (built[k] == NUL_CHAR) begin
					alive = 1'b0;
				end
			end
		end
		hit = ok;
	end

endmodule

@@ rtl/fds_scan.sv @@
// Byte-wise directory sector scan: tracks the position in the sector, keeps
// the name bytes of the current entry and captures the fields of the first match.
// Depends on fds_pkg and fds_name_match.
module fds_scan
	import fds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	input  logic [7:0]   data_byte,
	input  logic [63:0]  name_head,
	input  logic [31:0]  name_tail,
	output logic         result_valid,
	output scan_result_t result
);

	logic [POS_W-1:0] pos_q;
	entry_name_t      head_q;
	logic             stop_q;
	logic             seen_q;
	logic [3:0]       idx_q;
	logic [15:0]      clus_q;
	logic [31:0]      len_q;

	logic [OFF_W-1:0] off;
	logic [ENT_W-1:0] ent;
	logic             name_hit;
	logic             attr_ok;
	logic             in_match;
	logic             last_byte;
	logic [31:0]      len_d;

	assign off       = pos_q[OFF_W-1:0];
	assign ent       = pos_q[POS_W-1:OFF_W];
	assign attr_ok   = (data_byte & SKIP_ATTR_MASK) == 8'h00;
	assign in_match  = seen_q && (ent == idx_q);
	assign last_byte = (pos_q == POS_LAST);

	fds_name_match u_match (
		.entry_name (head_q),
		.name_head  (name_head),
		.name_tail  (name_tail),
		.hit        (name_hit)
	);

	// The last length byte can arrive together with the end of the sector.
	always_comb begin
		len_d = len_q;
		if (in_match && off >= OFF_LENGTH) begin
			len_d[8*off[1:0] +: 8] = data_byte;
		end
	end

	assign result_valid          = byte_valid && last_byte;
	assign result.found          = seen_q;
	assign result.entry_index    = idx_q;
	assign result.start_cluster  = clus_q;
	assign result.file_length    = len_d;

	always_ff @(posedge clk) begin
		if (byte_valid && off < OFF_ATTR) begin
			head_q[off[3:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			stop_q <= 1'b0;
			seen_q <= 1'b0;
			idx_q  <= '0;
			clus_q <= '0;
			len_q  <= '0;
		end else if (byte_valid) begin
			if (last_byte) begin
				pos_q  <= '0;
				stop_q <= 1'b0;
				seen_q <= 1'b0;
				idx_q  <= '0;
				clus_q <= '0;
				len_q  <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				len_q <= len_d;
				if (!stop_q && off == OFF_ATTR && attr_ok) begin
					if (head_q[0] == NUL_CHAR) begin
						stop_q <= 1'b1;
					end else if (name_hit) begin
						stop_q <= 1'b1;
						seen_q <= 1'b1;
						idx_q  <= ent;
					end
				end
				if (in_match && off == OFF_CLUSTER_L) begin
					clus_q[7:0] <= data_byte;
				end
				if (in_match && off == OFF_CLUSTER_H) begin
					clus_q[15:8] <= data_byte;
				end
			end
		end
	end

endmodule

@@ rtl/fat16_directory_name_search.sv @@
// Searches one 512-byte FAT16 directory sector, streamed one byte per word, for an
// 8.3 name and returns one word per sector; the core takes one byte every cycle, the result
// word is ready the cycle after byte 511 is accepted, and input stalls only while a result still waits downstream.
// Depends on fds_pkg, fds_scan and fds_name_match.
module fat16_directory_name_search
	import fds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // data_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// found, entry_index[3:0], start_cluster[15:0], file_length[31:0],
	// first_sector[31:0], zero padding
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [63:0]  name_head_q;
	logic [31:0]  name_tail_q;
	logic [31:0]  data_start_q;
	logic [7:0]   cluster_size_q;

	logic         byte_acc;
	logic         res_valid;
	scan_result_t res;
	logic [31:0]  cluster_off;
	logic [39:0]  sector_prod;
	logic [31:0]  first_sector;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_head_q    <= '0;
			name_tail_q    <= '0;
			data_start_q   <= '0;
			cluster_size_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NAME_HEAD:  name_head_q    <= cfg_data;
				CFG_NAME_TAIL:  name_tail_q    <= cfg_data[31:0];
				CFG_DATA_START: data_start_q   <= cfg_data[31:0];
				CFG_CLUSTER_SZ: cluster_size_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign byte_acc      = s_axis_tvalid && s_axis_tready;

	fds_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_acc),
		.data_byte    (s_axis_tdata),
		.name_head    (name_head_q),
		.name_tail    (name_tail_q),
		.result_valid (res_valid),
		.result       (res)
	);

	// Clusters are numbered from two; a smaller value wraps.
	assign cluster_off  = {16'd0, res.start_cluster} - 32'd2;
	assign sector_prod  = {8'd0, cluster_off} * {32'd0, cluster_size_q};
	assign first_sector = res.found ? (data_start_q + sector_prod[31:0]) : 32'd0;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= {(OUT_W - OUT_BITS)'(0), first_sector, res.file_length,
				res.start_cluster, res.entry_index, res.found};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/fds_checker.sv @@
// Port-level checks for the FAT16 directory name search block, and the bind
// that attaches them to the top level. Depends on fds_pkg.
module fds_port_checker
	import fds_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata
);

	logic [POS_W-1:0] count_q;
	logic             in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= count_q + 1'b1;
		end
	end

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// A new result appears only right after the last byte of a sector.
	a_result_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_acc && count_q == POS_LAST))
		else $error("result word without a completed sector");

	// With nothing held at the output, the block takes bytes.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output");

	// When nothing matched every other field is zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_W-1:1] == '0)
		else $error("nonzero fields on a miss");

endmodule

bind fat16_directory_name_search fds_port_checker u_fds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ sim/fds_checker.sv @@
// Scoreboard for the FAT16 directory name search block.
// Watches the byte stream, the result stream and the register port, predicts the lookup
// word of every sector and compares it field by field. Depends on fds_pkg.
module fds_checker
	import fds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        found;
		logic [3:0]  entry_index;
		logic [15:0] start_cluster;
		logic [31:0] file_length;
		logic [31:0] first_sector;
	} lookup_t;

	localparam int IDX_LSB = 1;
	localparam int CLU_LSB = 5;
	localparam int LEN_LSB = 21;
	localparam int SEC_LSB = 53;
	localparam int REPORT_LIMIT = 10;

	logic [63:0]      search_head;
	logic [31:0]      search_tail;
	logic [31:0]      data_start;
	logic [7:0]       cluster_size;

	logic [POS_W-1:0] byte_pos;
	logic [7:0]       head_bytes [12];
	logic             stopped;
	logic             seen;
	logic [3:0]       hit_index;
	logic [15:0]      hit_cluster;
	logic [31:0]      hit_length;

	lookup_t expected_lookups [$];
	int      mismatches = 0;
	int      outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	// Character k of the search name; a NUL always follows the twelfth one.
	function automatic logic [7:0] wanted_char(int k);
		if (k < 8)
			return search_head[8*k +: 8];
		if (k < 12)
			return search_tail[8*(k-8) +: 8];
		return NUL_CHAR;
	endfunction

	function automatic logic name_hit();
		logic [7:0] built [13];
		int         cut;
		foreach (built[k])
			built[k] = NUL_CHAR;
		cut = 0;
		while (cut < 8 && head_bytes[cut] != SPACE_CHAR)
			cut++;
		for (int k = 0; k < cut; k++)
			built[k] = head_bytes[k];
		built[cut] = DOT_CHAR;
		for (int k = 0; k < 3; k++)
			built[cut+1+k] = head_bytes[8+k];
		// Compared as C strings: equal up to and including the first NUL.
		for (int k = 0; k < 13; k++) begin
			if (built[k] != wanted_char(k))
				return 1'b0;
			if (built[k] == NUL_CHAR)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic new_sector();
		byte_pos    = '0;
		stopped     = 1'b0;
		seen        = 1'b0;
		hit_index   = '0;
		hit_cluster = '0;
		hit_length  = '0;
	endtask

	task automatic advance(input logic [7:0] value);
		logic [OFF_W-1:0] off;
		logic [3:0]       ent;
		lookup_t          lookup;
		off = byte_pos[OFF_W-1:0];
		ent = byte_pos[POS_W-1:OFF_W];
		if (off < 12)
			head_bytes[off] = value;
		if (!stopped && off == OFF_ATTR && (value & SKIP_ATTR_MASK) == 8'h00) begin
			if (head_bytes[0] == NUL_CHAR) begin
				stopped = 1'b1;
			end else if (name_hit()) begin
				stopped   = 1'b1;
				seen      = 1'b1;
				hit_index = ent;
			end
		end
		if (seen && ent == hit_index) begin
			if (off == OFF_CLUSTER_L)
				hit_cluster[7:0] = value;
			else if (off == OFF_CLUSTER_H)
				hit_cluster[15:8] = value;
			else if (off >= OFF_LENGTH)
				hit_length[8*(off-OFF_LENGTH) +: 8] = value;
		end
		if (byte_pos == POS_LAST) begin
			lookup.found         = seen;
			lookup.entry_index   = seen ? hit_index : 4'd0;
			lookup.start_cluster = seen ? hit_cluster : 16'd0;
			lookup.file_length   = seen ? hit_length : 32'd0;
			lookup.first_sector  = seen ? data_start + (32'(hit_cluster) - 32'd2) *
				32'(cluster_size) : 32'd0;
			expected_lookups.push_back(lookup);
			new_sector();
		end else begin
			byte_pos = byte_pos + 1'b1;
		end
	endtask

	task automatic check_result(input logic [OUT_W-1:0] word);
		lookup_t got;
		lookup_t want;
		got.found         = word[0];
		got.entry_index   = word[IDX_LSB +: 4];
		got.start_cluster = word[CLU_LSB +: 16];
		got.file_length   = word[LEN_LSB +: 32];
		got.first_sector  = word[SEC_LSB +: 32];
		if (expected_lookups.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: lookup word %h arrived with no sector pending", $realtime, word);
		end else begin
			want = expected_lookups.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: lookup mismatch, expected found=%0d entry=%0d cluster=%h",
						$realtime, want.found, want.entry_index, want.start_cluster);
					$display("    length=%h sector=%h, got found=%0d entry=%0d cluster=%h",
						want.file_length, want.first_sector, got.found, got.entry_index,
						got.start_cluster);
					$display("    length=%h sector=%h", got.file_length, got.first_sector);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_head  = '0;
			search_tail  = '0;
			data_start   = '0;
			cluster_size = 8'd1;
			foreach (head_bytes[k])
				head_bytes[k] = NUL_CHAR;
			new_sector();
			expected_lookups.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_NAME_HEAD:  search_head = cfg_data;
					CFG_NAME_TAIL:  search_tail = cfg_data[31:0];
					CFG_DATA_START: data_start = cfg_data[31:0];
					CFG_CLUSTER_SZ: cluster_size = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				advance(s_axis_tdata);
		end
		outstanding = expected_lookups.size();
	end

endmodule

@@ sim/testbench.sv @@
// Top of the simulation for the FAT16 directory name search block.
// Streams directed and random directory sectors under changing search settings and gives
// the verdict; prediction and comparison live in fds_checker. Depends on fds_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fds_pkg::*;

	localparam int RANDOM_SECTORS = 48;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 1_000_000;

	localparam logic [7:0] ATTR_HIDDEN = 8'h02;
	localparam logic [7:0] ATTR_VOLUME = 8'h08;
	localparam logic [7:0] ATTR_DIR    = 8'h10;

	typedef enum {
		ENT_NOISE,
		ENT_NOISE_SKIPPED,
		ENT_HIT,
		ENT_HIT_SKIPPED,
		ENT_NEAR,
		ENT_END,
		ENT_END_SKIPPED
	} entry_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    cycles;

	logic [7:0] sector_bytes [SECTOR_BYTES];
	// Bytes 0-10 of the entry that the current search name is built to find.
	logic [7:0] name_tpl [11];

	fat16_directory_name_search u_top (.*);
	fds_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("FAILURE");
		$finish;
	end

	// Result side: stalls most results for a random number of cycles once they show up, takes the rest at once.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (stall == 0) begin
				m_axis_tready <= 1'b1;
				do @(posedge clk); while (!m_axis_tvalid);
				@(negedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				do @(posedge clk); while (!m_axis_tvalid);
				@(negedge clk);
				repeat (stall - 1) @(negedge clk);
				m_axis_tready <= 1'b1;
				@(posedge clk);
				@(negedge clk);
			end
		end
	end

	task automatic push_byte(input logic [7:0] value, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_sector();
		bit paced;
		paced = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < SECTOR_BYTES; i++)
			push_byte(sector_bytes[i], paced ? $urandom_range(0, 6) : 0);
	endtask

	// Holds the byte stream until every lookup word has come back and the block is quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	task automatic configure(input logic [63:0] head, input logic [31:0] tail,
		input logic [31:0] start, input logic [7:0] csize);
		settle();
		write_reg(CFG_NAME_HEAD, head);
		write_reg(CFG_NAME_TAIL, {32'd0, tail});
		write_reg(CFG_DATA_START, {32'd0, start});
		write_reg(CFG_CLUSTER_SZ, {56'd0, csize});
		cfg_we <= 1'b0;
	endtask

	// Search name that the template entry spells: base cut at a space, dot, extension.
	function automatic void pack_search(output logic [63:0] head, output logic [31:0] tail);
		logic [7:0] text [12];
		int         cut;
		foreach (text[k])
			text[k] = NUL_CHAR;
		cut = 0;
		while (cut < 8 && name_tpl[cut] != SPACE_CHAR)
			cut++;
		for (int k = 0; k < cut; k++)
			text[k] = name_tpl[k];
		text[cut] = DOT_CHAR;
		for (int k = 0; k < 3; k++)
			text[cut+1+k] = name_tpl[8+k];
		for (int k = 0; k < 8; k++)
			head[8*k +: 8] = text[k];
		for (int k = 0; k < 4; k++)
			tail[8*k +: 8] = text[8+k];
	endfunction

	task automatic tpl_config(input logic [31:0] start, input logic [7:0] csize);
		logic [63:0] head;
		logic [31:0] tail;
		pack_search(head, tail);
		configure(head, tail, start, csize);
	endtask

	task automatic set_tpl(input string text);
		for (int k = 0; k < 11; k++)
			name_tpl[k] = text[k];
	endtask

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == SPACE_CHAR);
		return c;
	endfunction

	task automatic new_template();
		int len;
		len = $urandom_range(1, 8);
		for (int k = 0; k < 8; k++)
			name_tpl[k] = (k < len) ? name_char() : SPACE_CHAR;
		for (int k = 8; k < 11; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: name_tpl[k] = name_char();
				9: name_tpl[k] = NUL_CHAR;
				default: name_tpl[k] = SPACE_CHAR;
			endcase
		end
		if (len > 1 && $urandom_range(0, 7) == 0)
			name_tpl[$urandom_range(1, len - 1)] = NUL_CHAR;
	endtask

	function automatic logic [7:0] skip_bit();
		case ($urandom_range(0, 2))
			0: return ATTR_HIDDEN;
			1: return ATTR_VOLUME;
			default: return ATTR_DIR;
		endcase
	endfunction

	task automatic set_cluster(input int e, input logic [15:0] value);
		sector_bytes[e*ENTRY_BYTES + OFF_CLUSTER_L] = value[7:0];
		sector_bytes[e*ENTRY_BYTES + OFF_CLUSTER_H] = value[15:8];
	endtask

	task automatic fill_entry(input int e, input entry_kind_t kind);
		int at;
		int flip_at;
		at = e * ENTRY_BYTES;
		for (int k = 0; k < ENTRY_BYTES; k++)
			sector_bytes[at+k] = 8'($urandom);
		if (kind == ENT_HIT || kind == ENT_HIT_SKIPPED || kind == ENT_NEAR) begin
			for (int k = 0; k < 11; k++)
				sector_bytes[at+k] = name_tpl[k];
		end
		if (kind == ENT_NEAR) begin
			flip_at = at + $urandom_range(0, 10);
			sector_bytes[flip_at] = sector_bytes[flip_at] ^ 8'(1 << $urandom_range(0, 7));
		end
		if (kind == ENT_END || kind == ENT_END_SKIPPED)
			sector_bytes[at] = NUL_CHAR;
		case (kind)
			ENT_HIT, ENT_NEAR, ENT_END:
				sector_bytes[at+OFF_ATTR] = sector_bytes[at+OFF_ATTR] & ~SKIP_ATTR_MASK;
			ENT_HIT_SKIPPED, ENT_NOISE_SKIPPED, ENT_END_SKIPPED:
				sector_bytes[at+OFF_ATTR] = sector_bytes[at+OFF_ATTR] | skip_bit();
			default: ;
		endcase
		// Clusters below two make the first-sector arithmetic wrap.
		if (kind == ENT_HIT) begin
			case ($urandom_range(0, 7))
				0: set_cluster(e, 16'h0000);
				1: set_cluster(e, 16'h0001);
				2: set_cluster(e, 16'hFFFF);
				3: set_cluster(e, 16'h0002);
				default: ;
			endcase
		end
	endtask

	task automatic fill_sector(input entry_kind_t kind);
		for (int e = 0; e < SECTOR_BYTES / ENTRY_BYTES; e++)
			fill_entry(e, kind);
	endtask

	function automatic entry_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return ENT_NOISE;
		if (r < 45) return ENT_NEAR;
		if (r < 60) return ENT_HIT;
		if (r < 72) return ENT_HIT_SKIPPED;
		if (r < 84) return ENT_NOISE_SKIPPED;
		if (r < 92) return ENT_END_SKIPPED;
		return ENT_END;
	endfunction

	task automatic random_sector();
		if ($urandom_range(0, 9) == 0) begin
			foreach (sector_bytes[i])
				sector_bytes[i] = 8'($urandom);
		end else begin
			for (int e = 0; e < SECTOR_BYTES / ENTRY_BYTES; e++)
				fill_entry(e, pick_kind());
		end
	endtask

	task automatic random_config();
		logic [63:0] head;
		logic [63:0] junk;
		logic [31:0] tail;
		logic [31:0] start;
		logic [7:0]  csize;
		if ($urandom_range(0, 4) != 0) begin
			new_template();
			pack_search(head, tail);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					head = '0;
					tail = '0;
				end
				1: begin
					head = '1;
					tail = '1;
				end
				default: begin
					head = {$urandom, $urandom};
					tail = $urandom;
				end
			endcase
		end
		case ($urandom_range(0, 5))
			0: start = '0;
			1: start = '1;
			default: start = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: csize = 8'd0;
			1: csize = 8'd1;
			2: csize = 8'hFF;
			default: csize = 8'($urandom);
		endcase
		// Bits above a register's width must be dropped by the block.
		junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
		settle();
		write_reg(CFG_NAME_HEAD, head);
		write_reg(CFG_NAME_TAIL, {junk[63:32], tail});
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_DATA_START, {junk[63:32], start});
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_CLUSTER_SZ, {junk[63:8], csize});
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int run;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: an empty search name never matches.
		new_template();
		random_sector();
		send_sector();

		// Volume label, directory and hidden entries are passed over; the first match wins.
		set_tpl("README  TXT");
		tpl_config(32'd100, 8'd4);
		fill_sector(ENT_NOISE_SKIPPED);
		fill_entry(0, ENT_HIT_SKIPPED);
		sector_bytes[OFF_ATTR] = ATTR_VOLUME;
		fill_entry(1, ENT_HIT_SKIPPED);
		sector_bytes[ENTRY_BYTES + OFF_ATTR] = ATTR_DIR;
		fill_entry(2, ENT_HIT_SKIPPED);
		sector_bytes[2*ENTRY_BYTES + OFF_ATTR] = ATTR_HIDDEN;
		fill_entry(3, ENT_NEAR);
		fill_entry(4, ENT_HIT);
		set_cluster(4, 16'h0005);
		fill_entry(5, ENT_HIT);
		send_sector();

		// Full twelve-character name in the last entry; a skipped free entry does not stop.
		set_tpl("ABCDEFGHXYZ");
		tpl_config('1, 8'hFF);
		fill_sector(ENT_NEAR);
		fill_entry(0, ENT_END_SKIPPED);
		fill_entry(15, ENT_HIT);
		set_cluster(15, 16'h0000);
		send_sector();

		// A free entry ends the scan before the match.
		set_tpl("LOG     DAT");
		tpl_config('0, 8'd1);
		fill_sector(ENT_NOISE_SKIPPED);
		fill_entry(3, ENT_NEAR);
		fill_entry(5, ENT_END);
		fill_entry(7, ENT_HIT);
		send_sector();

		// A NUL inside the base ends the name early.
		set_tpl("AB XXXXXTXT");
		name_tpl[2] = NUL_CHAR;
		tpl_config(32'd1234, 8'd0);
		fill_sector(ENT_NOISE_SKIPPED);
		fill_entry(9, ENT_HIT);
		set_cluster(9, 16'h0001);
		send_sector();

		// Base made only of spaces gives a name that starts with the dot.
		set_tpl("        EXT");
		tpl_config('0, 8'hFF);
		fill_sector(ENT_NOISE_SKIPPED);
		fill_entry(0, ENT_HIT);
		set_cluster(0, 16'hFFFF);
		for (int k = 0; k < 4; k++)
			sector_bytes[OFF_LENGTH + k] = 8'hFF;
		send_sector();

		// Untrimmed extension with trailing spaces.
		set_tpl("A       B  ");
		tpl_config(32'h8000_0000, 8'd2);
		fill_sector(ENT_NEAR);
		fill_entry(2, ENT_HIT);
		fill_entry(14, ENT_HIT);
		send_sector();

		// All-ones and all-zeros sectors under all-ones settings.
		configure('1, '1, '1, 8'hFF);
		foreach (sector_bytes[i])
			sector_bytes[i] = 8'hFF;
		send_sector();
		foreach (sector_bytes[i])
			sector_bytes[i] = 8'h00;
		send_sector();

		sent = 0;
		while (sent < RANDOM_SECTORS) begin
			random_config();
			run = $urandom_range(1, 3);
			repeat (run) begin
				random_sector();
				send_sector();
				sent++;
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
